/* sv/avrq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package avrq_pkg;

  // Default sizes of the record store.
  localparam int STORE_BYTES_DEF      = 4096;
  localparam int HEADER_BYTES_DEF     = 16;
  localparam int MAX_RECORD_BYTES_DEF = 64;

  // Fixed layout constants.
  localparam int RESERVED_BYTES = 8;
  localparam int ALIGN_BYTES    = 4;

  // Register reset values.
  localparam logic [31:0] EXPIRY_RESET = 32'd10000;
  localparam logic [12:0] MSIZE_RESET  = 13'd4096;

  // Operation codes.
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ZERO  = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_SMALL = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;
  localparam logic [2:0] ST_CAP   = 3'd5;
  localparam logic [2:0] ST_FAULT = 3'd6;

  // Configuration register indexes.
  localparam logic REG_EXPIRY = 1'b0;
  localparam logic REG_MSIZE  = 1'b1;

  // One result item handed from the engine to the output stage.
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic [31:0] tag;
    logic [6:0]  res_length;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

/* sv/avrq_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module avrq_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] addr,
  input  wire logic          we,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Single port byte store with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* sv/avrq_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

module avrq_engine #(
  parameter int STORE_BYTES      = 4096,
  parameter int HEADER_BYTES     = 16,
  parameter int MAX_RECORD_BYTES = 64,
  parameter int AW               = 12,
  parameter int CW               = 14
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_take,
  output logic               busy,
  input  wire logic [1:0]    operation,
  input  wire logic [15:0]   push_length,
  input  wire logic [31:0]   push_tag,
  input  wire logic [7:0]    push_byte,
  input  wire logic          push_last,
  input  wire logic [15:0]   pop_capacity,
  input  wire logic [31:0]   expiry_period,
  input  wire logic [CW-1:0] msize,
  input  wire logic          can_emit,
  output logic               res_valid,
  output avrq_pkg::res_t     res,
  output logic [AW-1:0]      mem_addr,
  output logic               mem_we,
  output logic [7:0]         mem_wdata,
  input  wire logic [7:0]    mem_rdata
);

  import avrq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_RD, S_WR,
    S_PL_TAILLEN, S_PL_LOOP, S_PL_TIME, S_PL_NEXT, S_PL_EMPTYCHK,
    S_PL_OK, S_PL_HDR2, S_PL_HDR3, S_PL_HDR4,
    S_FILL, S_PAD, S_LINK,
    S_PO_START, S_PO_LEN, S_PO_TIME, S_PO_TAG, S_PO_NEXT,
    S_SRD, S_SCAP, S_SEM, S_EMIT
  } state_t;

  typedef enum logic [1:0] {PS_IDLE, PS_FILL, PS_DISCARD} push_state_t;

  localparam logic [CW-1:0] HDR   = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] RSV   = CW'(RESERVED_BYTES);
  localparam logic [CW-1:0] STORE = CW'(STORE_BYTES);
  localparam logic [CW-1:0] AMASK = ~CW'(ALIGN_BYTES - 1);
  localparam logic [15:0]   MAXL  = 16'(MAX_RECORD_BYTES);

  state_t      state, ret_state;
  push_state_t push_state;
  logic [2:0]  cnt, acc_n;
  logic [CW-1:0] acc_base;
  logic [31:0] acc, wval;
  logic [CW-1:0] head, tail, fillp, pend_start, pend_end, cand, guard, srec;
  logic [CW:0]   freed;
  logic        nonempty, live;
  logic [31:0] cur_time;
  logic [2:0]  push_result;
  logic [1:0]  op_q;
  logic [15:0] len_q, cap_q;
  logic [31:0] tag_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [6:0]  rlen, sidx;
  logic [31:0] rtag;
  logic [2:0]  e_status;
  logic [7:0]  e_byte;
  logic [31:0] e_tag;
  logic [6:0]  e_len;
  logic        e_last;

  // Derived values used by the sequencer.
  logic [CW-1:0]    need, nxt, cand_calc;
  logic [CW+15:0]   nxt_ext, ps_ext;
  logic [6:0]       rd_len;
  logic             expired;
  logic [CW-1:0]    rd_addr, srd_addr;

  always_comb begin
    need      = HDR + CW'(len_q);
    nxt_ext   = {{CW{1'b0}}, acc[31:16]};
    nxt       = nxt_ext[CW-1:0];
    ps_ext    = {16'h0000, pend_start};
    rd_len    = (acc[31:16] > MAXL) ? 7'(MAX_RECORD_BYTES) : acc[22:16];
    cand_calc = (tail + HDR + CW'(rd_len) + CW'(ALIGN_BYTES - 1)) & AMASK;
    expired   = (cur_time - acc) > expiry_period;
    rd_addr   = acc_base + CW'(cnt);
    srd_addr  = srec + HDR + CW'(sidx);
  end

  // Store port: address and write strobe follow the current step.
  always_comb begin
    mem_addr  = rd_addr[AW-1:0];
    mem_we    = 1'b0;
    mem_wdata = wval[7:0];
    case (state)
      S_WR: begin
        mem_we = 1'b1;
      end
      S_FILL: begin
        mem_addr  = fillp[AW-1:0];
        mem_we    = (push_state == PS_FILL) && (fillp < pend_end);
        mem_wdata = byte_q;
      end
      S_PAD: begin
        mem_addr  = fillp[AW-1:0];
        mem_we    = fillp < pend_end;
        mem_wdata = 8'h00;
      end
      S_SRD: begin
        mem_addr = srd_addr[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  assign busy      = (state != S_IDLE);
  assign res_valid = ((state == S_EMIT) || (state == S_SEM)) && can_emit;
  assign res       = '{status: e_status, data_byte: e_byte, tag: e_tag,
                       res_length: e_len, last: e_last};

  // Sequencer: state, queue pointers and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ret_state   <= S_IDLE;
      push_state  <= PS_IDLE;
      push_result <= ST_OK;
      head        <= '0;
      tail        <= '0;
      fillp       <= '0;
      nonempty    <= 1'b0;
      cur_time    <= '0;
      cnt         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_take) begin
            op_q   <= operation;
            len_q  <= push_length;
            tag_q  <= push_tag;
            byte_q <= push_byte;
            last_q <= push_last;
            cap_q  <= pop_capacity;
            state  <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (op_q)
            OP_PUSH: begin
              if (push_state == PS_IDLE) begin
                if (len_q == 16'h0000) begin
                  push_result <= ST_ZERO;
                  push_state  <= PS_DISCARD;
                  state       <= S_FILL;
                end else if (len_q > MAXL) begin
                  push_result <= ST_SMALL;
                  push_state  <= PS_DISCARD;
                  state       <= S_FILL;
                end else if (nonempty) begin
                  acc_base  <= tail + CW'(4);
                  acc_n     <= 3'd2;
                  cnt       <= '0;
                  ret_state <= S_PL_TAILLEN;
                  state     <= S_RD;
                end else begin
                  state <= S_PL_EMPTYCHK;
                end
              end else begin
                state <= S_FILL;
              end
            end
            OP_POP: begin
              guard <= '0;
              state <= S_PO_START;
            end
            OP_TICK: begin
              cur_time <= cur_time + 32'd1;
              state    <= S_IDLE;
            end
            default: state <= S_IDLE;
          endcase
        end
        // Read acc_n bytes little-endian; the value lands in the top bytes of acc.
        S_RD: begin
          if (cnt != 3'd0) begin
            acc <= {mem_rdata, acc[31:8]};
          end
          if (cnt == acc_n) begin
            state <= ret_state;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        // Write acc_n bytes of wval little-endian.
        S_WR: begin
          wval <= {8'h00, wval[31:8]};
          cnt  <= cnt + 3'd1;
          if (cnt == acc_n - 3'd1) begin
            state <= ret_state;
          end
        end
        // Placement: first candidate after the tail record, or the reserved offset when that does not fit.
        S_PL_TAILLEN: begin
          freed <= '0;
          guard <= '0;
          state <= S_PL_LOOP;
          if (tail >= head) begin
            if (cand_calc + need <= msize) begin
              cand  <= cand_calc;
              state <= S_PL_OK;
            end else begin
              cand <= RSV;
            end
          end else begin
            cand <= cand_calc;
          end
        end
        S_PL_LOOP: begin
          if ((guard > STORE) || (head > msize) || (freed > {1'b0, msize})) begin
            push_result <= ST_FAULT;
            push_state  <= PS_DISCARD;
            state       <= S_FILL;
          end else if (cand + need <= head) begin
            state <= S_PL_OK;
          end else begin
            acc_base  <= head + CW'(8);
            acc_n     <= 3'd4;
            cnt       <= '0;
            ret_state <= S_PL_TIME;
            state     <= S_RD;
          end
        end
        S_PL_TIME: begin
          if (!expired) begin
            push_result <= ST_FULL;
            push_state  <= PS_DISCARD;
            state       <= S_FILL;
          end else begin
            acc_base  <= head + CW'(6);
            acc_n     <= 3'd2;
            cnt       <= '0;
            ret_state <= S_PL_NEXT;
            state     <= S_RD;
          end
        end
        // Free the expired head record.
        S_PL_NEXT: begin
          if (nxt == '0) begin
            if (tail != head) begin
              push_result <= ST_FAULT;
              push_state  <= PS_DISCARD;
              state       <= S_FILL;
            end else begin
              nonempty <= 1'b0;
              head     <= '0;
              tail     <= '0;
              state    <= S_PL_EMPTYCHK;
            end
          end else if (nxt < head) begin
            freed <= freed + {1'b0, msize - head};
            head  <= nxt;
            if (cand + need <= msize) begin
              state <= S_PL_OK;
            end else begin
              cand  <= RSV;
              guard <= guard + CW'(1);
              state <= S_PL_LOOP;
            end
          end else begin
            freed <= freed + {1'b0, nxt - head};
            head  <= nxt;
            guard <= guard + CW'(1);
            state <= S_PL_LOOP;
          end
        end
        S_PL_EMPTYCHK: begin
          if (RSV + need <= msize) begin
            cand  <= RSV;
            state <= S_PL_OK;
          end else begin
            push_result <= ST_SMALL;
            push_state  <= PS_DISCARD;
            state       <= S_FILL;
          end
        end
        // Header: tag, then length with a null link, then push time.
        S_PL_OK: begin
          push_result <= ST_OK;
          wval        <= tag_q;
          acc_base    <= cand;
          acc_n       <= 3'd4;
          cnt         <= '0;
          ret_state   <= S_PL_HDR2;
          state       <= S_WR;
        end
        S_PL_HDR2: begin
          wval      <= {16'h0000, len_q};
          acc_base  <= cand + CW'(4);
          cnt       <= '0;
          ret_state <= S_PL_HDR3;
          state     <= S_WR;
        end
        S_PL_HDR3: begin
          wval      <= cur_time;
          acc_base  <= cand + CW'(8);
          cnt       <= '0;
          ret_state <= S_PL_HDR4;
          state     <= S_WR;
        end
        S_PL_HDR4: begin
          pend_start <= cand;
          fillp      <= cand + HDR;
          pend_end   <= cand + HDR + CW'(len_q);
          push_state <= PS_FILL;
          state      <= S_FILL;
        end
        // Payload byte of this transfer.
        S_FILL: begin
          if ((push_state == PS_FILL) && (fillp < pend_end)) begin
            fillp <= fillp + CW'(1);
          end
          if (!last_q) begin
            state <= S_IDLE;
          end else if (push_state == PS_FILL) begin
            state <= S_PAD;
          end else begin
            push_state <= PS_IDLE;
            e_status   <= push_result;
            e_byte     <= '0;
            e_tag      <= '0;
            e_len      <= '0;
            e_last     <= 1'b1;
            state      <= S_EMIT;
          end
        end
        // Zero the undelivered bytes, then link the record in.
        S_PAD: begin
          if (fillp < pend_end) begin
            fillp <= fillp + CW'(1);
          end else if (nonempty) begin
            wval      <= {16'h0000, ps_ext[15:0]};
            acc_base  <= tail + CW'(6);
            acc_n     <= 3'd2;
            cnt       <= '0;
            ret_state <= S_LINK;
            state     <= S_WR;
          end else begin
            head     <= pend_start;
            nonempty <= 1'b1;
            state    <= S_LINK;
          end
        end
        S_LINK: begin
          tail       <= pend_start;
          push_state <= PS_IDLE;
          e_status   <= push_result;
          e_byte     <= '0;
          e_tag      <= '0;
          e_len      <= '0;
          e_last     <= 1'b1;
          state      <= S_EMIT;
        end
        // Pop: walk past expired records.
        S_PO_START: begin
          e_byte <= '0;
          e_tag  <= '0;
          e_len  <= '0;
          e_last <= 1'b1;
          if (guard > STORE) begin
            e_status <= ST_FAULT;
            state    <= S_EMIT;
          end else if (!nonempty) begin
            e_status <= ST_EMPTY;
            state    <= S_EMIT;
          end else begin
            acc_base  <= head + CW'(4);
            acc_n     <= 3'd2;
            cnt       <= '0;
            ret_state <= S_PO_LEN;
            state     <= S_RD;
          end
        end
        S_PO_LEN: begin
          rlen <= rd_len;
          if ({9'h000, rd_len} > cap_q) begin
            e_status <= ST_CAP;
            state    <= S_EMIT;
          end else begin
            acc_base  <= head + CW'(8);
            acc_n     <= 3'd4;
            cnt       <= '0;
            ret_state <= S_PO_TIME;
            state     <= S_RD;
          end
        end
        S_PO_TIME: begin
          cnt   <= '0;
          state <= S_RD;
          if (expired) begin
            live      <= 1'b0;
            acc_base  <= head + CW'(6);
            acc_n     <= 3'd2;
            ret_state <= S_PO_NEXT;
          end else begin
            acc_base  <= head;
            acc_n     <= 3'd4;
            ret_state <= S_PO_TAG;
          end
        end
        S_PO_TAG: begin
          rtag      <= acc;
          srec      <= head;
          live      <= 1'b1;
          acc_base  <= head + CW'(6);
          acc_n     <= 3'd2;
          cnt       <= '0;
          ret_state <= S_PO_NEXT;
          state     <= S_RD;
        end
        S_PO_NEXT: begin
          if (nxt != '0) begin
            head <= nxt;
          end else begin
            nonempty <= 1'b0;
            head     <= '0;
            tail     <= '0;
          end
          if (!live) begin
            guard <= guard + CW'(1);
            state <= S_PO_START;
          end else if (rlen == 7'd0) begin
            e_status <= ST_OK;
            e_tag    <= rtag;
            state    <= S_EMIT;
          end else begin
            sidx  <= '0;
            state <= S_SRD;
          end
        end
        // Stream the payload byte by byte: read, capture, then emit, which waits on a stalled output.
        S_SRD: begin
          state <= S_SCAP;
        end
        S_SCAP: begin
          e_status <= ST_OK;
          e_byte   <= mem_rdata;
          e_tag    <= rtag;
          e_len    <= rlen;
          e_last   <= (sidx + 7'd1 == rlen);
          state    <= S_SEM;
        end
        S_SEM: begin
          if (can_emit) begin
            if (e_last) begin
              state <= S_IDLE;
            end else begin
              sidx  <= sidx + 7'd1;
              state <= S_SRD;
            end
          end
        end
        S_EMIT: begin
          if (can_emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/aging_variable_record_ring_queue_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid / in_stall  operation, push_length, push_tag, push_byte,
//                                push_last, pop_capacity
// output    out_valid/out_stall  status, out_byte, out_tag, out_length, out_last
// config    cfg_write_enable     cfg_index, cfg_data
//
// One item is worked on at a time through the single port byte store.
// A first push byte may free expired head records, and a pop skips
// expired records before it streams the payload bytes.
// Synchronous reset empties the queue; the store needs no clearing pass.
// A stalled output holds the engine at its next result; input stays stalled.

module aging_variable_record_ring_queue_top #(
  parameter int STORE_BYTES      = avrq_pkg::STORE_BYTES_DEF,
  parameter int HEADER_BYTES     = avrq_pkg::HEADER_BYTES_DEF,
  parameter int MAX_RECORD_BYTES = avrq_pkg::MAX_RECORD_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [15:0] push_length,
  input  wire logic [31:0] push_tag,
  input  wire logic [7:0]  push_byte,
  input  wire logic        push_last,
  input  wire logic [15:0] pop_capacity,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [7:0]       out_byte,
  output logic [31:0]      out_tag,
  output logic [6:0]       out_length,
  output logic             out_last,
  input  wire logic        cfg_write_enable,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  import avrq_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam int CW = AW + 2;

  logic [31:0]   expiry_period;
  logic [12:0]   memory_size_in_use;
  logic [CW-1:0] msize;
  logic          busy, can_emit, res_valid;
  res_t          res;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    mem_wdata, mem_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      expiry_period      <= EXPIRY_RESET;
      memory_size_in_use <= MSIZE_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_EXPIRY: expiry_period      <= cfg_data;
        REG_MSIZE:  memory_size_in_use <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  // Store size in use, limited to the physical store.
  always_comb begin
    if (32'(memory_size_in_use) > 32'(STORE_BYTES)) begin
      msize = CW'(STORE_BYTES);
    end else begin
      msize = CW'(memory_size_in_use);
    end
  end

  assign in_stall = busy;
  assign can_emit = !out_valid || !out_stall;

  avrq_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .addr  (mem_addr),
    .we    (mem_we),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  avrq_engine #(
    .STORE_BYTES      (STORE_BYTES),
    .HEADER_BYTES     (HEADER_BYTES),
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
    .AW               (AW),
    .CW               (CW)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .item_take     (in_valid && !in_stall),
    .busy          (busy),
    .operation     (operation),
    .push_length   (push_length),
    .push_tag      (push_tag),
    .push_byte     (push_byte),
    .push_last     (push_last),
    .pop_capacity  (pop_capacity),
    .expiry_period (expiry_period),
    .msize         (msize),
    .can_emit      (can_emit),
    .res_valid     (res_valid),
    .res           (res),
    .mem_addr      (mem_addr),
    .mem_we        (mem_we),
    .mem_wdata     (mem_wdata),
    .mem_rdata     (mem_rdata)
  );

  // Output register: loaded by the engine, cleared once the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      status     <= res.status;
      out_byte   <= res.data_byte;
      out_tag    <= res.tag;
      out_length <= res.res_length;
      out_last   <= res.last;
    end
  end

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import avrq_pkg::*;

  localparam int STORE   = STORE_BYTES_DEF;
  localparam int HDR     = HEADER_BYTES_DEF;
  localparam int MAX_REC = MAX_RECORD_BYTES_DEF;
  localparam logic [1:0] OP_NONE = 2'd3;
  // Quiet time that covers the longest push allocation walk.
  localparam int SETTLE_CYCLES = 3000;

  typedef enum int {FILL_IDLE, FILL_BYTES, FILL_DISCARD} fill_state_e;

  // One directed transfer; a fixed row carries its result typed in.
  typedef struct {
    logic [1:0]  op;
    logic [15:0] len;
    logic [31:0] tag;
    logic [7:0]  data;
    logic        last;
    logic [15:0] cap;
    bit          fixed;
    logic [2:0]  want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = OP_TICK;
  logic [15:0] push_length = '0;
  logic [31:0] push_tag = '0;
  logic [7:0]  push_byte = '0;
  logic        push_last = 1'b0;
  logic [15:0] pop_capacity = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [7:0]  out_byte;
  logic [31:0] out_tag;
  logic [6:0]  out_length;
  logic        out_last;
  logic        cfg_write_enable = 1'b0;
  logic        cfg_index = REG_EXPIRY;
  logic [31:0] cfg_data = '0;

  aging_variable_record_ring_queue_top DUT (.*);

  always #5 clk = ~clk;

  // Shadow copy of the record store and its pointers.
  logic [7:0]  shadow_store [STORE];
  int unsigned head_at, tail_at, clock_now, fill_at, rec_start, rec_end;
  bit          has_records;
  fill_state_e fill_state;
  logic [2:0]  push_status;
  int unsigned expiry_ticks, mem_bytes;

  res_t        expected_results [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          sender_gap = 0;
  int          receiver_gap = 0;

  function automatic int unsigned rd8(int unsigned a);
    return shadow_store[a % STORE];
  endfunction
  function automatic void wr8(int unsigned a, int unsigned v);
    shadow_store[a % STORE] = v[7:0];
  endfunction
  function automatic int unsigned rd16(int unsigned a);
    return rd8(a) | (rd8(a + 1) << 8);
  endfunction
  function automatic void wr16(int unsigned a, int unsigned v);
    wr8(a, v);
    wr8(a + 1, v >> 8);
  endfunction
  function automatic int unsigned rd32(int unsigned a);
    return rd16(a) | (rd16(a + 2) << 16);
  endfunction
  function automatic void wr32(int unsigned a, int unsigned v);
    wr16(a, v);
    wr16(a + 2, v >> 16);
  endfunction

  function automatic int unsigned length_of(int unsigned r);
    int unsigned n;
    n = rd16(r + 4);
    return (n > MAX_REC) ? MAX_REC : n;
  endfunction

  function automatic bit is_stale(int unsigned r);
    int unsigned age;
    age = clock_now - rd32(r + 8);
    return age > expiry_ticks;
  endfunction

  function automatic void unlink_head();
    int unsigned n;
    n = rd16(head_at + 6);
    if (n != 0) begin
      head_at = n;
    end else begin
      has_records = 0;
      head_at = 0;
      tail_at = 0;
    end
  endfunction

  function automatic void add_result(logic [2:0] st, logic [7:0] b, logic [31:0] tg,
                                     int unsigned ln, bit lst);
    res_t r;
    r.status = st;
    r.data_byte = b;
    r.tag = tg;
    r.res_length = ln[6:0];
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  // Finds room for a new record, freeing stale records at the head.
  function automatic logic [2:0] find_room(int unsigned len, output int unsigned at);
    int unsigned msz, need, cand, freed, nxt;
    msz = (mem_bytes > STORE) ? STORE : mem_bytes;
    need = HDR + len;
    freed = 0;
    at = 0;
    if (has_records) begin
      cand = (tail_at + HDR + length_of(tail_at) + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
      if (tail_at >= head_at) begin
        if (cand + need <= msz) begin
          at = cand;
          return ST_OK;
        end
        cand = RESERVED_BYTES;
      end
      for (int unsigned guard = 0; ; guard++) begin
        if (guard > STORE || head_at > msz || freed > msz) return ST_FAULT;
        if (cand + need <= head_at) begin
          at = cand;
          return ST_OK;
        end
        if (!is_stale(head_at)) return ST_FULL;
        nxt = rd16(head_at + 6);
        if (nxt == 0) begin
          if (tail_at != head_at) return ST_FAULT;
          unlink_head();
          break;
        end
        if (nxt < head_at) begin
          freed += msz - head_at;
          head_at = nxt;
          if (cand + need <= msz) begin
            at = cand;
            return ST_OK;
          end
          cand = RESERVED_BYTES;
        end else begin
          freed += nxt - head_at;
          head_at = nxt;
        end
      end
    end
    if (RESERVED_BYTES + need <= msz) begin
      at = RESERVED_BYTES;
      return ST_OK;
    end
    return ST_SMALL;
  endfunction

  // Works out the results of one accepted input transfer.
  function automatic void predict_queue(logic [1:0] op, logic [15:0] len, logic [31:0] tag,
                                        logic [7:0] b, logic lst, logic [15:0] cap);
    int unsigned at, r, n;
    logic [31:0] tg;
    logic [2:0]  st;
    if (op == OP_PUSH) begin
      if (fill_state == FILL_IDLE) begin
        if (len == 0) st = ST_ZERO;
        else if (len > MAX_REC) st = ST_SMALL;
        else st = find_room(len, at);
        push_status = st;
        if (st == ST_OK) begin
          wr32(at, tag);
          wr16(at + 4, len);
          wr16(at + 6, 0);
          wr32(at + 8, clock_now);
          rec_start = at;
          fill_at = at + HDR;
          rec_end = fill_at + len;
          fill_state = FILL_BYTES;
        end else begin
          fill_state = FILL_DISCARD;
        end
      end
      if (fill_state == FILL_BYTES && fill_at < rec_end) begin
        wr8(fill_at, b);
        fill_at++;
      end
      if (!lst) return;
      if (fill_state == FILL_BYTES) begin
        while (fill_at < rec_end) begin
          wr8(fill_at, 0);
          fill_at++;
        end
        if (has_records) begin
          wr16(tail_at + 6, rec_start);
        end else begin
          head_at = rec_start;
          has_records = 1;
        end
        tail_at = rec_start;
      end
      fill_state = FILL_IDLE;
      add_result(push_status, 0, 0, 0, 1);
    end else if (op == OP_POP) begin
      for (int unsigned guard = 0; guard <= STORE; guard++) begin
        if (!has_records) begin
          add_result(ST_EMPTY, 0, 0, 0, 1);
          return;
        end
        r = head_at;
        n = length_of(r);
        if (n > cap) begin
          add_result(ST_CAP, 0, 0, 0, 1);
          return;
        end
        if (!is_stale(r)) begin
          tg = rd32(r);
          unlink_head();
          if (n == 0) begin
            add_result(ST_OK, 0, tg, 0, 1);
            return;
          end
          for (int unsigned i = 0; i < n; i++)
            add_result(ST_OK, rd8(r + HDR + i), tg, n, (i + 1) == n);
          return;
        end
        unlink_head();
      end
      add_result(ST_FAULT, 0, 0, 0, 1);
    end else if (op == OP_TICK) begin
      clock_now++;
    end
  endfunction

  // Drives one transfer and returns once the block has taken it.
  task automatic send_item(logic [1:0] op, logic [15:0] len, logic [31:0] tag,
                           logic [7:0] b, logic lst, logic [15:0] cap, output bit taken);
    @(negedge clk);
    if ($urandom_range(99) < sender_gap) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    push_length <= len;
    push_tag <= tag;
    push_byte <= b;
    push_last <= lst;
    pop_capacity <= cap;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
    taken = 1;
  endtask

  task automatic send_predicted(logic [1:0] op, logic [15:0] len, logic [31:0] tag,
                                logic [7:0] b, logic lst, logic [15:0] cap);
    bit ok;
    send_item(op, len, tag, b, lst, cap, ok);
    predict_queue(op, len, tag, b, lst, cap);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    if (idx == REG_EXPIRY) expiry_ticks = value;
    else mem_bytes = value[12:0];
  endtask

  // Receiver stall pattern, changed on the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_gap);
  end

  // Result checker.
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result status=%0d byte=%h tag=%h len=%0d last=%b",
                   status, out_byte, out_tag, out_length, out_last);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || out_byte !== want.data_byte || out_tag !== want.tag ||
            out_length !== want.res_length || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: expected status=%0d byte=%h tag=%h len=%0d last=%b, got %0d %h %h %0d %b",
                     want.status, want.data_byte, want.tag, want.res_length, want.last,
                     status, out_byte, out_tag, out_length, out_last);
        end
      end
    end
  end

  // Directed rows: extremes, short and surplus pushes, pop in mid push, empty.
  row_t directed [] = '{
    '{OP_POP,  16'd0,     32'h0,        8'h00, 1'b0, 16'd64,    1'b1, ST_EMPTY},
    '{OP_PUSH, 16'd0,     32'h1,        8'h11, 1'b1, 16'd0,     1'b1, ST_ZERO},
    '{OP_PUSH, 16'hFFFF,  32'hFFFFFFFF, 8'hFF, 1'b1, 16'hFFFF,  1'b1, ST_SMALL},
    '{OP_PUSH, 16'd65,    32'h2,        8'h22, 1'b1, 16'd0,     1'b1, ST_SMALL},
    '{OP_PUSH, 16'd1,     32'h0,        8'h00, 1'b1, 16'd0,     1'b1, ST_OK},
    '{OP_POP,  16'd0,     32'h0,        8'h00, 1'b0, 16'd0,     1'b1, ST_CAP},
    '{OP_POP,  16'd0,     32'h0,        8'h00, 1'b0, 16'hFFFF,  1'b0, ST_OK},
    '{OP_PUSH, 16'd64,    32'hFFFFFFFF, 8'hFF, 1'b1, 16'd0,     1'b1, ST_OK},
    '{OP_PUSH, 16'd2,     32'h5,        8'hAA, 1'b0, 16'd0,     1'b0, ST_OK},
    '{OP_NONE, 16'hFFFF,  32'hFFFFFFFF, 8'hFF, 1'b1, 16'hFFFF,  1'b0, ST_OK},
    '{OP_POP,  16'd0,     32'h0,        8'h00, 1'b0, 16'd64,    1'b0, ST_OK},
    '{OP_PUSH, 16'd2,     32'h5,        8'h55, 1'b1, 16'd0,     1'b1, ST_OK},
    '{OP_PUSH, 16'd1,     32'hA5A5A5A5, 8'h01, 1'b0, 16'd0,     1'b0, ST_OK},
    '{OP_PUSH, 16'd1,     32'hA5A5A5A5, 8'h02, 1'b1, 16'd0,     1'b1, ST_OK},
    '{OP_TICK, 16'd0,     32'h0,        8'h00, 1'b0, 16'd0,     1'b0, ST_OK},
    '{OP_POP,  16'd0,     32'h0,        8'h00, 1'b0, 16'd1,     1'b0, ST_OK},
    '{OP_POP,  16'd0,     32'h0,        8'h00, 1'b0, 16'hFFFF,  1'b0, ST_OK},
    '{OP_POP,  16'd0,     32'h0,        8'h00, 1'b0, 16'hFFFF,  1'b0, ST_OK},
    '{OP_POP,  16'd0,     32'h0,        8'h00, 1'b0, 16'hFFFF,  1'b1, ST_EMPTY}
  };

  // Register settings per random phase, extremes included.
  logic [31:0] phase_expiry [6] = '{32'd0, 32'd3, 32'd20, 32'hFFFFFFFF, 32'd5, 32'd10000};
  logic [31:0] phase_msize  [6] = '{32'd32, 32'd100, 32'd4096, 32'd200, 32'd8191, 32'd64};

  initial begin
    bit ok;
    int count, nbytes, len, sel;
    logic [31:0] tag;
    head_at = 0; tail_at = 0; clock_now = 0; fill_at = 0;
    rec_start = 0; rec_end = 0; has_records = 0;
    fill_state = FILL_IDLE; push_status = ST_OK;
    expiry_ticks = EXPIRY_RESET; mem_bytes = MSIZE_RESET;
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    sender_gap = 30;
    receiver_gap = 68;

    // Directed rows; fixed rows are checked against the typed status.
    foreach (directed[i]) begin
      send_item(directed[i].op, directed[i].len, directed[i].tag, directed[i].data,
                directed[i].last, directed[i].cap, ok);
      if (directed[i].fixed) begin
        predict_queue(directed[i].op, directed[i].len, directed[i].tag, directed[i].data,
                      directed[i].last, directed[i].cap);
        void'(expected_results.pop_back());
        add_result(directed[i].want, 0, 0, 0, 1);
      end else begin
        predict_queue(directed[i].op, directed[i].len, directed[i].tag, directed[i].data,
                      directed[i].last, directed[i].cap);
      end
    end

    // Random phases, each under its own register settings.
    for (int p = 0; p < 6; p++) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_reg(REG_EXPIRY, phase_expiry[p]);
      write_reg(REG_MSIZE, phase_msize[p]);
      sender_gap   = (p < 2) ? 30 : (p < 4) ? 68 : 0;
      receiver_gap = (p < 2) ? 68 : (p < 4) ? 30 : 0;
      count = 0;
      while (count < 65) begin
        if (count >= 32 && count < 36) begin
          // Hold the sender back until the output side has caught up.
          drain_results();
          count = 36;
        end
        sel = $urandom_range(99);
        if (sel < 50) begin
          sel = $urandom_range(99);
          if (sel < 85) len = $urandom_range(12, 1);
          else if (sel < 93) len = $urandom_range(64, 13);
          else if (sel < 97) len = 0;
          else len = $urandom_range(65535, 65);
          if (len == 0 || len > MAX_REC) nbytes = $urandom_range(3, 1);
          else if ($urandom_range(99) < 80) nbytes = len;
          else nbytes = $urandom_range(len + 2, 1);
          tag = $urandom;
          for (int i = 0; i < nbytes; i++) begin
            if (i > 0 && $urandom_range(99) < 5) begin
              send_predicted(OP_POP, $urandom, $urandom, $urandom, $urandom,
                             $urandom_range(65535, 64));
              count++;
            end
            send_predicted(OP_PUSH, len, tag, $urandom, i == nbytes - 1, $urandom);
            count++;
          end
        end else if (sel < 75) begin
          send_predicted(OP_POP, $urandom, $urandom, $urandom, $urandom,
                         ($urandom_range(99) < 80) ? $urandom_range(65535, 64)
                                                   : $urandom_range(70, 0));
          count++;
        end else if (sel < 95) begin
          send_predicted(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
          count++;
        end else begin
          send_predicted(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d input transfers and %0d result transfers over six settings,",
             items_sent, results_seen);
    $display("with %0d mismatches and %0d results still outstanding.",
             mismatches, expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung block.
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
